// File: src/four_operator_wavetable_envelope_mixer_core_assert.svh
// Assertion macros shared by the envelope mixer RTL.
`ifndef FOUR_OPERATOR_WAVETABLE_ENVELOPE_MIXER_CORE_ASSERT_SVH
`define FOUR_OPERATOR_WAVETABLE_ENVELOPE_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FWEM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FWEM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/fwem_pkg.sv
// Shared constants, command/status types and the shape ROM of the envelope mixer.
`default_nettype none
package fwem_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int WAVE_POINTS = 16;
   localparam int OPS         = 4;
   localparam int K_W         = $clog2(OPS);
   localparam int P_W         = $clog2(TABLE_DEPTH);
   localparam int RAM_DEPTH   = OPS * TABLE_DEPTH;
   localparam int RAM_AW      = K_W + P_W;
   localparam int NIB_W       = 4;
   localparam int SHAPE_W     = 3;
   localparam int SHAPES      = 8;
   localparam int ENV_W       = 4 * NIB_W;
   localparam int SHAPES_REG_W = OPS * SHAPE_W;
   localparam int VOL_W       = 4;
   localparam int PROD_W      = 2 * NIB_W;
   // four lane terms of at most 13 each
   localparam int ACC_W       = 6;
   localparam int WAVE_W      = NIB_W * WAVE_POINTS;
   // lengths sum to at most 60
   localparam int SUM_W       = 6;
   localparam int CMP_W       = (P_W > SUM_W) ? P_W : SUM_W;
   localparam int DIVD_W      = NIB_W;
   localparam int DIVS_W      = NIB_W + 1;

   localparam logic [NIB_W-1:0] LEVEL_MAX = 4'hF;
   localparam logic [P_W-1:0]   P_LAST    = P_W'(TABLE_DEPTH - 1);

   // register map, word index
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENV0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENV1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENV2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENV3   = 3'd4;

   // divider operand selection
   localparam logic [1:0] DIV_ATTACK  = 2'd0;
   localparam logic [1:0] DIV_RELEASE = 2'd1;
   localparam logic [1:0] DIV_DECAY   = 2'd2;

   // point i of a shape in bits 4i+3..4i
   localparam logic [SHAPES-1:0][WAVE_W-1:0] SHAPE_ROM = {
      64'h30000004_BFFFFFFC,  // square
      64'h4037BFC8_4037BFC8,  // triangle x2
      64'h64201357_9BDFECA8,  // triangle
      64'h74100136_9BEFFECA,  // sine
      64'h64321100_FFEEDCB8,  // shark
      64'h51D9C2D9_51D9C2D9,  // saw x4
      64'h7531ECA8_6420FDB9,  // saw x2
      64'h76543210_FEDCBA98   // saw
   };

   typedef struct packed {
      logic       take_req;
      logic       load_op;
      logic       div_start;
      logic [1:0] div_sel;
      logic       latch_c;
      logic       latch_q;
      logic       step;
      logic       next_op;
      logic       set_built;
      logic       mul_vol;
      logic       acc_lane;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic a_nz;
      logic r_nz;
      logic is_decay;
      logic p_last;
      logic op_last;
      logic div_done;
      logic div_busy;
      logic out_free;
      logic built;
   } stat_type;

endpackage
`default_nettype wire

// File: src/fwem_if.sv
// Tick and wave channel interfaces of the envelope mixer.
`default_nettype none
interface fwem_req_if;
   import fwem_pkg::*;
   logic             valid;
   logic             ready;
   logic             retrigger;
   logic [VOL_W-1:0] volume;
   modport source (output valid, retrigger, volume, input ready);
   modport sink (input valid, retrigger, volume, output ready);
endinterface

interface fwem_rsp_if;
   import fwem_pkg::*;
   logic              valid;
   logic              ready;
   logic [WAVE_W-1:0] wave_samples;
   modport source (output valid, wave_samples, input ready);
   modport sink (input valid, wave_samples, output ready);
endinterface
`default_nettype wire

// File: src/fwem_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fwem_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: src/fwem_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fwem_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fwem_pkg::DIVD_W-1:0]  dividend,
   input  logic [fwem_pkg::DIVS_W-1:0]  divisor,
   output logic [fwem_pkg::DIVD_W-1:0]  quotient,
   output logic                         busy,
   output logic                         done
);
   import fwem_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVD_W - 1);

   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIVS_W'(trial - {1'b0, den_ff}) : trial[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

// File: src/fwem_dp.sv
// Datapath: envelope table builder, table RAM, operator scaling and wave lanes.
`default_nettype none
module fwem_dp (
   input  logic                                        clock,
   input  logic                                        reset,
   input  fwem_pkg::cmd_type                           cmd,
   output fwem_pkg::stat_type                          stat,
   input  logic                                        req_retrigger,
   input  logic [fwem_pkg::VOL_W-1:0]                  req_volume,
   input  logic [fwem_pkg::SHAPES_REG_W-1:0]           shapes,
   input  logic [fwem_pkg::OPS-1:0][fwem_pkg::ENV_W-1:0] env_len,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [fwem_pkg::WAVE_W-1:0]                 rsp_wave_samples
);
   import fwem_pkg::*;

   logic [K_W-1:0]    k_ff, k_in;
   logic [P_W-1:0]    p_ff, p_in;
   logic [P_W-1:0]    pos_ff, pos_in;
   logic [NIB_W-1:0]  level_ff, level_in;
   logic [NIB_W-1:0]  c_ff, c_in;
   logic [NIB_W-1:0]  q_ff, q_in;
   logic [VOL_W-1:0]  vol_ff, vol_in;
   logic [NIB_W-1:0]  v_ff, v_in;
   logic              built_ff, built_in;
   logic              valid_ff, valid_in;
   logic [WAVE_W-1:0] wave_ff, wave_in;
   logic [ACC_W-1:0]  acc_ff [WAVE_POINTS];
   logic [ACC_W-1:0]  acc_in [WAVE_POINTS];
   logic [PROD_W-1:0] lane_prod [WAVE_POINTS];

   logic [ENV_W-1:0]   lens;
   logic [NIB_W-1:0]   len_a, len_d, len_s, len_r, s_eff;
   logic [CMP_W-1:0]   sum_a, sum_ad, sum_ads, sum_n, p_ext;
   logic               in_attack, in_decay, in_hold, in_live;
   logic [NIB_W-1:0]   lvl_step, entry;
   logic [DIVD_W-1:0]  div_a;
   logic [DIVS_W-1:0]  div_b;
   logic [DIVD_W-1:0]  div_q;
   logic               div_busy, div_done;
   logic [NIB_W-1:0]   ram_rdata, env_level;
   logic [PROD_W-1:0]  env_prod;
   logic [SHAPE_W-1:0] shape_sel;

   // decode the current operator's lengths and its walk phase
   always_comb begin
      lens      = env_len[k_ff];
      len_a     = lens[0*NIB_W +: NIB_W];
      len_d     = lens[1*NIB_W +: NIB_W];
      len_s     = lens[2*NIB_W +: NIB_W];
      len_r     = lens[3*NIB_W +: NIB_W];
      s_eff     = (len_s != '0) ? len_s : LEVEL_MAX;
      sum_a     = CMP_W'(len_a);
      sum_ad    = sum_a + CMP_W'(len_d);
      sum_ads   = sum_ad + CMP_W'(len_s);
      sum_n     = sum_ads + CMP_W'(len_r);
      p_ext     = CMP_W'(p_ff);
      in_attack = p_ext < sum_a;
      in_decay  = !in_attack && (p_ext < sum_ad);
      in_hold   = p_ext < sum_ads;
      in_live   = p_ext < sum_n;
   end

   // (60/a)>>2 == 15/a, (4L/x)>>2 == L/x, (4S/r)>>2 == S/r
   always_comb begin
      unique case (cmd.div_sel)
         DIV_ATTACK: begin
            div_a = LEVEL_MAX;
            div_b = {1'b0, len_a};
         end
         DIV_RELEASE: begin
            div_a = s_eff;
            div_b = {1'b0, len_r};
         end
         DIV_DECAY: begin
            div_a = level_ff;
            div_b = {1'b0, len_d} + {1'b0, len_s};
         end
         default: begin
            div_a = '0;
            div_b = '0;
         end
      endcase
   end

   fwem_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .quotient (div_q),
      .busy     (div_busy),
      .done     (div_done)
   );

   always_comb begin
      priority if (in_attack) begin
         lvl_step = level_ff + c_ff;
      end else if (in_decay) begin
         lvl_step = level_ff - div_q;
      end else if (in_hold) begin
         lvl_step = level_ff;
      end else if (in_live) begin
         lvl_step = (q_ff > level_ff) ? '0 : level_ff - q_ff;
      end else begin
         lvl_step = level_ff;
      end
      entry = in_live ? lvl_step : '0;
   end

   fwem_ram #(
      .WIDTH (NIB_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.step),
      .waddr ({k_ff, p_ff}),
      .wdata (entry),
      .raddr ({k_ff, pos_ff}),
      .rdata (ram_rdata)
   );

   // tables read as zero until the first rebuild
   always_comb begin
      env_level = built_ff ? ram_rdata : '0;
      env_prod  = PROD_W'(env_level) * PROD_W'(vol_ff);
      shape_sel = shapes[SHAPE_W*k_ff +: SHAPE_W];
      for (int i = 0; i < WAVE_POINTS; i++) begin
         lane_prod[i] = PROD_W'(SHAPE_ROM[shape_sel][NIB_W*i +: NIB_W]) * PROD_W'(v_ff);
         if (cmd.take_req) begin
            acc_in[i] = '0;
         end else if (cmd.acc_lane) begin
            acc_in[i] = acc_ff[i] + ACC_W'(lane_prod[i][PROD_W-1:NIB_W]);
         end else begin
            acc_in[i] = acc_ff[i];
         end
         wave_in[NIB_W*i +: NIB_W] = cmd.load_out ? acc_ff[i][ACC_W-1:2]
                                                   : wave_ff[NIB_W*i +: NIB_W];
      end
   end

   always_comb begin
      k_in     = cmd.take_req ? '0 : (cmd.next_op ? k_ff + K_W'(1) : k_ff);
      p_in     = cmd.load_op ? '0 : (cmd.step ? p_ff + P_W'(1) : p_ff);
      pos_in   = pos_ff;
      if (cmd.take_req && req_retrigger) begin
         pos_in = '0;
      end else if (cmd.load_out && (pos_ff != P_LAST)) begin
         pos_in = pos_ff + P_W'(1);
      end
      level_in = level_ff;
      if (cmd.load_op) begin
         level_in = (len_a != '0) ? '0 : LEVEL_MAX;
      end else if (cmd.step) begin
         level_in = lvl_step;
      end
      c_in     = cmd.latch_c ? div_q : c_ff;
      q_in     = cmd.latch_q ? div_q : q_ff;
      vol_in   = cmd.take_req ? req_volume : vol_ff;
      v_in     = cmd.mul_vol ? env_prod[PROD_W-1:NIB_W] : v_ff;
      built_in = built_ff | cmd.set_built;
      valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         pos_ff   <= '0;
         built_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         pos_ff   <= pos_in;
         built_ff <= built_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      level_ff <= level_in;
      c_ff     <= c_in;
      q_ff     <= q_in;
      vol_ff   <= vol_in;
      v_ff     <= v_in;
      wave_ff  <= wave_in;
      acc_ff   <= acc_in;
   end

   always_comb begin
      stat.a_nz     = len_a != '0;
      stat.r_nz     = len_r != '0;
      stat.is_decay = in_decay;
      stat.p_last   = p_ff == P_LAST;
      stat.op_last  = k_ff == K_W'(OPS - 1);
      stat.div_done = div_done;
      stat.div_busy = div_busy;
      stat.out_free = !valid_ff || rsp_ready;
      stat.built    = built_ff;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_wave_samples = wave_ff;
endmodule
`default_nettype wire

// File: src/fwem_ctrl.sv
// Sequencer: table rebuild walk and per-tick rendering of the four operators.
`default_nettype none
module fwem_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_retrigger,
   output logic               req_ready,
   input  fwem_pkg::stat_type stat,
   output fwem_pkg::cmd_type  cmd
);
   import fwem_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LOAD  = 4'd1;
   localparam logic [3:0] ST_DIVA  = 4'd2;
   localparam logic [3:0] ST_WAITA = 4'd3;
   localparam logic [3:0] ST_DIVR  = 4'd4;
   localparam logic [3:0] ST_WAITR = 4'd5;
   localparam logic [3:0] ST_WALK  = 4'd6;
   localparam logic [3:0] ST_WAITD = 4'd7;
   localparam logic [3:0] ST_NEXT  = 4'd8;
   localparam logic [3:0] ST_READ  = 4'd9;
   localparam logic [3:0] ST_VOL   = 4'd10;
   localparam logic [3:0] ST_ACC   = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
            if (req_valid) begin
               state_in = req_retrigger ? ST_LOAD : ST_READ;
            end
         end
         ST_LOAD: begin
            cmd.load_op = 1'b1;
            state_in    = ST_DIVA;
         end
         ST_DIVA: begin
            if (stat.a_nz) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_ATTACK;
               state_in      = ST_WAITA;
            end else begin
               state_in = ST_DIVR;
            end
         end
         ST_WAITA: begin
            cmd.div_sel = DIV_ATTACK;
            if (stat.div_done) begin
               cmd.latch_c = 1'b1;
               state_in    = ST_DIVR;
            end
         end
         ST_DIVR: begin
            if (stat.r_nz) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_RELEASE;
               state_in      = ST_WAITR;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WAITR: begin
            cmd.div_sel = DIV_RELEASE;
            if (stat.div_done) begin
               cmd.latch_q = 1'b1;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            if (stat.is_decay) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_DECAY;
               state_in      = ST_WAITD;
            end else begin
               cmd.step = 1'b1;
               if (stat.p_last) begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_WAITD: begin
            cmd.div_sel = DIV_DECAY;
            if (stat.div_done) begin
               cmd.step = 1'b1;
               state_in = stat.p_last ? ST_NEXT : ST_WALK;
            end
         end
         ST_NEXT: begin
            cmd.next_op = 1'b1;
            if (stat.op_last) begin
               cmd.set_built = 1'b1;
               state_in      = ST_READ;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_READ: begin
            state_in = ST_VOL;
         end
         ST_VOL: begin
            cmd.mul_vol = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_lane = 1'b1;
            cmd.next_op  = 1'b1;
            state_in     = stat.op_last ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// File: src/four_operator_wavetable_envelope_mixer_core.sv
// Top level of the four-operator wavetable envelope mixer.
// Each tick word (retrigger, volume) yields one 64-bit wave word of sixteen
// 4-bit points. A tick without retrigger goes from acceptance to the wave
// register through an accept step, then per operator a table RAM read, volume
// scaling and a sixteen-lane shape accumulate, then an output load once free.
// A retrigger first rebuilds all four 64-entry envelope tables, one entry a
// cycle except that each decay entry waits on the shared 4-step restoring
// divider, plus up to two divisions per operator for the attack slope and
// release step, each skipped when its length is zero. Tables live in one
// 256 x 4 RAM; a rebuild rewrites every entry,
// and a flag masks the RAM to zero until the first rebuild, so no clearing
// pass runs after reset. The wave register parts the two channels: the next
// tick is taken while a finished wave still waits. Registers sit on an APB
// port at byte addresses 0 (shapes) and 4..16 (operator 0..3 lengths);
// write them only while the block is idle.
`default_nettype none
`include "four_operator_wavetable_envelope_mixer_core_assert.svh"
module four_operator_wavetable_envelope_mixer_core (
   input  logic                              clock,
   input  logic                              reset,
   fwem_req_if.sink                          req_chan,
   fwem_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fwem_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fwem_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fwem_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import fwem_pkg::*;

   // configuration registers
   logic [SHAPES_REG_W-1:0]         shapes_ff, shapes_in;
   logic [OPS-1:0][ENV_W-1:0]       env_ff, env_in;
   logic [CSR_IDX_W-1:0]            csr_idx;
   logic [CSR_IDX_W-1:0]            env_sel;
   logic                            csr_wr;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign env_sel = csr_idx - CSR_ENV0;
   assign csr_wr  = psel && penable && pwrite && pready;

   // write decode; drop writes past the last register
   always_comb begin
      shapes_in = shapes_ff;
      env_in    = env_ff;
      if (csr_wr) begin
         priority if (csr_idx == CSR_SHAPES) begin
            shapes_in = pwdata[SHAPES_REG_W-1:0];
         end else if ((csr_idx >= CSR_ENV0) && (csr_idx <= CSR_ENV3)) begin
            env_in[env_sel[K_W-1:0]] = pwdata[ENV_W-1:0];
         end else begin
            shapes_in = shapes_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shapes_ff <= '0;
         env_ff    <= '0;
      end else begin
         shapes_ff <= shapes_in;
         env_ff    <= env_in;
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_SHAPES: prdata = CSR_DATA_W'(shapes_ff);
         CSR_ENV0:   prdata = CSR_DATA_W'(env_ff[0]);
         CSR_ENV1:   prdata = CSR_DATA_W'(env_ff[1]);
         CSR_ENV2:   prdata = CSR_DATA_W'(env_ff[2]);
         CSR_ENV3:   prdata = CSR_DATA_W'(env_ff[3]);
         default:    prdata = '0;
      endcase
   end

   // sequencer: owns the tick handshake and steps the datapath
   fwem_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_retrigger (req_chan.retrigger),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   assign req_chan.ready = req_ready;

   // datapath: table build, table RAM, scaling, lanes and wave register
   fwem_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_retrigger    (req_chan.retrigger),
      .req_volume       (req_chan.volume),
      .shapes           (shapes_ff),
      .env_len          (env_ff),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_wave_samples (rsp_chan.wave_samples)
   );

   // an accepted tick keeps the block busy for at least the next cycle
   `FWEM_ASSERT_NXT(a_busy_after_accept, req_chan.valid && req_ready, !req_ready, "tick accepted back to back")
   // never restart the divider while it is still iterating
   `FWEM_ASSERT_IMP(a_div_start_idle, cmd.div_start, !stat.div_busy, "divider restarted while busy")
   // once built, tables stay valid
   `FWEM_ASSERT_NXT(a_built_sticky, stat.built, stat.built, "table valid flag dropped")
   // never overwrite a wave that still waits
   `FWEM_ASSERT_IMP(a_no_wave_overwrite, cmd.load_out, !rsp_chan.valid || rsp_chan.ready, "pending wave overwritten")
endmodule
`default_nettype wire

// File: bench/four_operator_wavetable_envelope_mixer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the four-operator wavetable envelope mixer core.
module four_operator_wavetable_envelope_mixer_core_tb;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 8;

   // envelope and wave geometry as the mixer defines it
   localparam int         ENV_DEPTH   = 64;
   localparam int         OPERATORS   = 4;
   localparam int         POINTS      = 16;
   localparam int         LEVEL_FULL  = 15;
   localparam int         ATTACK_SPAN = 60;
   localparam logic [5:0] POS_LAST    = 6'd63;

   // run shape
   localparam int RANDOM_SETTINGS   = 7;
   localparam int TICKS_PER_SETTING = 60;
   localparam int QUIET_LIMIT       = 6000;
   localparam int SETTLE_CYCLES     = 40;
   localparam int REPORT_LIMIT      = 10;

   // waveform shapes, point i in bits 4i+3..4i, shape 0 at index 0
   localparam logic [7:0][63:0] SHAPE_WORDS = {
      64'h30000004_BFFFFFFC,  // square
      64'h4037BFC8_4037BFC8,  // triangle x2
      64'h64201357_9BDFECA8,  // triangle
      64'h74100136_9BEFFECA,  // sine
      64'h64321100_FFEEDCB8,  // shark
      64'h51D9C2D9_51D9C2D9,  // saw x4
      64'h7531ECA8_6420FDB9,  // saw x2
      64'h76543210_FEDCBA98   // saw
   };

   typedef logic [fwem_pkg::CSR_IDX_W-1:0] reg_index_type;

   typedef struct packed {
      logic       retrigger;
      logic [3:0] volume;
   } tick_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [fwem_pkg::CSR_ADDR_W-1:0]   paddr;
   logic [fwem_pkg::CSR_DATA_W-1:0]   pwdata;
   logic [fwem_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   fwem_req_if req_chan ();
   fwem_rsp_if rsp_chan ();

   four_operator_wavetable_envelope_mixer_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Mixer state mirror: registers, envelope tables and envelope position
   // ---------------------------------------------------------------------
   logic [11:0] shape_sel;
   logic [15:0] env_lengths [OPERATORS];
   logic [3:0]  env_level [OPERATORS][ENV_DEPTH];
   logic [5:0]  env_pos;

   tick_word_type pending_ticks [$];
   logic [63:0]   wave_expected [$];

   int   ticks_queued    = 0;
   int   ticks_accepted  = 0;
   int   waves_checked   = 0;
   int   mismatches      = 0;
   int   rebuilds        = 0;
   int   saturated_ticks = 0;
   int   settings_loaded = 0;
   int   gap_left        = 0;
   int   burst_left      = 0;
   int   quiet_cycles    = 0;
   logic tick_taken      = 1'b0;

   // Rebuild one operator's table from its attack/decay/sustain/release nibbles.
   function automatic void rebuild_envelope(int k);
      int unsigned a, d, s, r, n, level, q;
      int          p;
      a = env_lengths[k][3:0];
      d = env_lengths[k][7:4];
      s = env_lengths[k][11:8];
      r = env_lengths[k][15:12];
      n = a + d + s + r;
      // without an attack the envelope opens at full level
      level = (a > 0) ? 0 : LEVEL_FULL;
      for (p = 0; p < ENV_DEPTH; p++)
         env_level[k][p] = '0;
      // stop at the table end even if the lengths run past it
      for (p = 0; p < n && p < ENV_DEPTH; p++) begin
         if (p < a) begin
            level = ((ATTACK_SPAN / a) >> 2) * (p + 1);
         end else if (p < a + d) begin
            level = level - (((level << 2) / (d + s)) >> 2);
         end else if (p >= a + d + s) begin
            // release step borrows a full sustain when sustain is empty; clamp at zero
            q = ((((s > 0) ? s : LEVEL_FULL) << 2) / r) >> 2;
            level = (q > level) ? 0 : level - q;
         end
         env_level[k][p] = 4'(level);
      end
   endfunction

   // Advance the mirror by one tick word and return the wave it must produce.
   function automatic logic [63:0] render_wave(tick_word_type t);
      int unsigned op_level [OPERATORS];
      int unsigned sum;
      logic [2:0]  sel;
      logic [63:0] wave;
      int          k, i;
      wave = '0;
      if (t.retrigger) begin
         env_pos = '0;
         for (k = 0; k < OPERATORS; k++)
            rebuild_envelope(k);
         rebuilds++;
      end
      if (env_pos == POS_LAST)
         saturated_ticks++;
      for (k = 0; k < OPERATORS; k++)
         op_level[k] = (int'(env_level[k][env_pos]) * t.volume) >> 4;
      // hold the position at the last entry once reached
      if (env_pos != POS_LAST)
         env_pos++;
      for (i = 0; i < POINTS; i++) begin
         sum = 0;
         for (k = 0; k < OPERATORS; k++) begin
            sel = shape_sel[3*k +: 3];
            sum += (int'(SHAPE_WORDS[sel][4*i +: 4]) * op_level[k]) >> 4;
         end
         wave[4*i +: 4] = 4'(sum >> 2);
      end
      return wave;
   endfunction

   function automatic void apply_register(reg_index_type idx, logic [31:0] value);
      case (idx)
         fwem_pkg::CSR_SHAPES: begin
            shape_sel = value[11:0];
         end
         fwem_pkg::CSR_ENV0, fwem_pkg::CSR_ENV1, fwem_pkg::CSR_ENV2, fwem_pkg::CSR_ENV3: begin
            env_lengths[idx - fwem_pkg::CSR_ENV0] = value[15:0];
         end
         default: begin
            // unmapped index: drop the write
         end
      endcase
   endfunction

   function automatic logic [31:0] register_value(reg_index_type idx);
      if (idx == fwem_pkg::CSR_SHAPES)
         return {20'd0, shape_sel};
      return {16'd0, env_lengths[idx - fwem_pkg::CSR_ENV0]};
   endfunction

   function automatic logic [15:0] random_lengths();
      logic [15:0] v;
      int          n;
      case ($urandom_range(0, 5))
         0: v = 16'h0000;
         1: v = 16'hFFFF;
         2: begin
            // sparse: many empty phases
            for (n = 0; n < 4; n++)
               v[4*n +: 4] = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
         end
         default: v = 16'($urandom());
      endcase
      return v;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   // ---------------------------------------------------------------------
   // Register port: APB access with setup and access phases, data changes on the falling edge
   // ---------------------------------------------------------------------
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      apply_register(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read_check(reg_index_type idx);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (prdata !== register_value(idx))
         report_mismatch("register readback", register_value(idx), prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write every register (junk in the unused upper bits), poke the unmapped
   // indexes, then read the real ones back.
   task automatic load_setting(logic [11:0] shapes, logic [3:0][15:0] lengths);
      int j;
      csr_write(fwem_pkg::CSR_SHAPES, {20'($urandom()), shapes});
      for (j = 0; j < OPERATORS; j++)
         csr_write(reg_index_type'(int'(fwem_pkg::CSR_ENV0) + j), {16'($urandom()), lengths[j]});
      for (j = int'(fwem_pkg::CSR_ENV3) + 1; j < (1 << fwem_pkg::CSR_IDX_W); j++)
         csr_write(reg_index_type'(j), $urandom());
      for (j = int'(fwem_pkg::CSR_SHAPES); j <= int'(fwem_pkg::CSR_ENV3); j++)
         csr_read_check(reg_index_type'(j));
      settings_loaded++;
   endtask

   task automatic queue_tick(logic retrig, logic [3:0] vol);
      tick_word_type t;
      t.retrigger = retrig;
      t.volume    = vol;
      pending_ticks.push_back(t);
      ticks_queued++;
   endtask

   // Mostly notes (retrigger then a run of plain ticks), some of them long
   // enough to park the envelope at its end, mixed with short noise bursts.
   task automatic queue_random_ticks(int target);
      int         count, len, i;
      logic [3:0] vol;
      count = 0;
      while (count < target) begin
         if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
               queue_tick(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 80) : $urandom_range(1, 16);
            vol = 4'($urandom_range(0, 15));
            queue_tick(1'b1, vol);
            for (i = 1; i < len; i++) begin
               if ($urandom_range(0, 3) == 0)
                  vol = 4'($urandom_range(0, 15));
               queue_tick(1'b0, vol);
            end
         end
         count += len;
      end
   endtask

   // Block until every queued tick word is taken and every wave word is back.
   task automatic wait_idle();
      while (ticks_accepted != ticks_queued || wave_expected.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tick driver: bursts of random length separated by random gaps
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_ticks
      tick_word_type t;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !tick_taken) begin
         // hold the word until the block takes it
      end else if (gap_left != 0) begin
         req_chan.valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_ticks.size() != 0) begin
         t = pending_ticks.pop_front();
         req_chan.valid     <= 1'b1;
         req_chan.retrigger <= t.retrigger;
         req_chan.volume    <= t.volume;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            // a quarter of the bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Wave receiver: ready follows a random 8-bit pattern, reloaded after its last bit;
   // about a third of the patterns are all ones, and none is all zeros
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : pace_waves
      logic [7:0] pattern;
      int         step;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         pattern = 8'hFF;
         step    = 0;
      end else begin
         if (step == 0) begin
            pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom());
            if (pattern == 8'h00)
               pattern = 8'h01;
         end
         rsp_chan.ready <= pattern[step];
         step = (step + 1) % 8;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each wave word against the oldest expectation, then
   // predict the wave for a tick word taken at this edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_words
      logic [63:0] want;
      if (reset) begin
         tick_taken <= 1'b0;
      end else begin
         tick_taken <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (wave_expected.size() == 0) begin
               report_mismatch("wave word with nothing pending", '0, rsp_chan.wave_samples);
            end else begin
               want = wave_expected.pop_front();
               waves_checked++;
               if (rsp_chan.wave_samples !== want)
                  report_mismatch("wave_samples", want, rsp_chan.wave_samples);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            wave_expected.push_back(render_wave(tick_word_type'{retrigger: req_chan.retrigger,
                                                                volume:    req_chan.volume}));
            ticks_accepted++;
         end
      end
   end

   // Watchdog: end the run after too long without any word moving.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : run_test
      int               phase, k, p;
      logic [3:0][15:0] lens;

      req_chan.valid     = 1'b0;
      req_chan.retrigger = 1'b0;
      req_chan.volume    = '0;
      rsp_chan.ready     = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;

      // mirror starts from the reset state
      shape_sel = '0;
      env_pos   = '0;
      for (k = 0; k < OPERATORS; k++) begin
         env_lengths[k] = '0;
         for (p = 0; p < ENV_DEPTH; p++)
            env_level[k][p] = '0;
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Fresh from reset, no retrigger yet: tables are empty, waves all zero.
      // Then retrigger with all lengths still zero.
      queue_tick(1'b0, 4'hF);
      queue_tick(1'b0, 4'h0);
      queue_tick(1'b0, 4'h8);
      queue_tick(1'b1, 4'hF);
      queue_tick(1'b0, 4'h7);
      wait_idle();

      // Shapes 0..3 and envelopes covering: full-length phases, attack into
      // sustain, no attack (opens at full level), release clamped at zero,
      // release with empty sustain.
      lens = {16'h1003, 16'h3020, 16'h0F01, 16'hFFFF};
      load_setting(12'h688, lens);
      queue_tick(1'b1, 4'hF);
      queue_tick(1'b0, 4'hF);
      queue_tick(1'b0, 4'hF);
      queue_tick(1'b0, 4'hF);
      queue_tick(1'b0, 4'h1);
      queue_tick(1'b0, 4'h0);
      queue_tick(1'b0, 4'hF);
      queue_tick(1'b1, 4'h8);
      queue_tick(1'b0, 4'hF);
      queue_tick(1'b0, 4'hF);
      wait_idle();

      // Shapes 4..7 with every length at its maximum.
      lens = {4{16'hFFFF}};
      load_setting(12'hFAC, lens);
      queue_tick(1'b1, 4'hF);
      repeat (5) queue_tick(1'b0, 4'hF);
      queue_tick(1'b1, 4'h0);
      queue_tick(1'b0, 4'hF);
      wait_idle();

      // Random settings, each driven with notes and noise.
      for (phase = 0; phase < RANDOM_SETTINGS; phase++) begin
         for (k = 0; k < OPERATORS; k++)
            lens[k] = random_lengths();
         load_setting(12'($urandom()), lens);
         queue_random_ticks(TICKS_PER_SETTING);
         wait_idle();
      end

      // Let any stray wave word show up before judging.
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d tick words over %0d register settings: %0d table rebuilds,",
               ticks_accepted, settings_loaded, rebuilds);
      $display("%0d ticks at the held envelope end, %0d wave words checked, %0d mismatches.",
               saturated_ticks, waves_checked, mismatches);
      if (mismatches == 0 && wave_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
